>>> rtl/core/kft_pkg.sv
// Package for the keyed flag table: size constants, operation and status codes,
// and the request, response and table entry types.
// Has no dependencies.
package kft_pkg;

    localparam int ENTRIES = 16;
    // At least one index bit, so that a one-entry table still elaborates
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Fill count and scan index must be able to hold ENTRIES itself
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int USED_W  = 5;

    localparam logic [1:0] OP_SAVE  = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_UPDATED  = 2'd0;
    localparam logic [1:0] STATUS_INSERTED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED  = 2'd2;
    localparam logic [1:0] STATUS_NONE     = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic        new_active;
        logic        new_acked;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic              got_active;
        logic              got_acked;
        logic [USED_W-1:0] used_entries;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic        active;
        logic        acked;
    } entry_t;

endpackage

>>> rtl/core/keyed_flag_table_unit.sv
// Clear and unused ops finish from the idle state without a scan; save and get scan
// the filled entries from index 0 until a match or the end of the filled part.
// A start is taken only in the idle state; busy is high during the scan and the next
// transfer can be taken in the cycle that done is high. One 32-bit comparator steps
// over the entries, one per cycle. The receiver cannot stall the response.
// Reset (rst_n, async, active low) empties the table; entry contents are kept.
// Keyed flag table: FSM, scan counter, entry store and response register.
// Depends on kft_pkg.
module keyed_flag_table_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  kft_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output kft_pkg::rsp_t rsp
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [kft_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [kft_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic                         done_reg, done_next;
    kft_pkg::req_t                req_reg, req_next;
    kft_pkg::rsp_t                rsp_reg, rsp_next;

    kft_pkg::entry_t              store_reg [kft_pkg::ENTRIES];
    kft_pkg::entry_t              rd_entry;
    kft_pkg::entry_t              wr_entry;
    logic                         wr_en;
    logic [kft_pkg::IDX_W-1:0]    idx_addr;
    logic                         at_end;
    logic                         match;
    logic                         room;

    assign idx_addr = idx_reg[kft_pkg::IDX_W-1:0];
    assign rd_entry = store_reg[idx_addr];
    assign at_end   = (idx_reg == fill_reg);
    // the shared comparator
    assign match    = (rd_entry.key == req_reg.key);
    assign room     = (fill_reg < kft_pkg::CNT_W'(kft_pkg::ENTRIES));

    assign wr_entry.key    = req_reg.key;
    assign wr_entry.active = req_reg.new_active;
    assign wr_entry.acked  = req_reg.new_acked;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        done_next  = 1'b0;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    idx_next = '0;
                    rsp_next.status       = kft_pkg::STATUS_NONE;
                    rsp_next.found        = 1'b0;
                    rsp_next.got_active   = 1'b0;
                    rsp_next.got_acked    = 1'b0;
                    rsp_next.used_entries = kft_pkg::USED_W'(fill_reg);
                    if (req.op == kft_pkg::OP_SAVE || req.op == kft_pkg::OP_GET)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        if (req.op == kft_pkg::OP_CLEAR)
                        begin
                            fill_next             = '0;
                            rsp_next.used_entries = '0;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (at_end)
                begin
                    // no match among filled entries
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (req_reg.op == kft_pkg::OP_SAVE)
                    begin
                        if (room)
                        begin
                            // append: the scan index already equals the fill count
                            wr_en                 = 1'b1;
                            fill_next             = fill_reg + 1'b1;
                            rsp_next.status       = kft_pkg::STATUS_INSERTED;
                            rsp_next.used_entries = kft_pkg::USED_W'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            rsp_next.status = kft_pkg::STATUS_DROPPED;
                        end
                    end
                end
                else if (match)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (req_reg.op == kft_pkg::OP_SAVE)
                    begin
                        wr_en           = 1'b1;
                        rsp_next.status = kft_pkg::STATUS_UPDATED;
                    end
                    else
                    begin
                        rsp_next.found      = 1'b1;
                        rsp_next.got_active = rd_entry.active;
                        rsp_next.got_acked  = rd_entry.acked;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        if (wr_en)
        begin
            store_reg[idx_addr] <= wr_entry;
        end
    end

    assign busy = (state_reg == ST_SCAN);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= kft_pkg::CNT_W'(kft_pkg::ENTRIES))
        else $error("fill count above table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= fill_reg))
        else $error("scan index past fill count");

    a_found_get_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.found) |-> (rsp.status == kft_pkg::STATUS_NONE))
        else $error("found flagged on a save");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == kft_pkg::STATUS_INSERTED) |->
            (fill_reg == $past(fill_reg) + 1'b1))
        else $error("insert without fill count step");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == kft_pkg::STATUS_DROPPED) |->
            (fill_reg == kft_pkg::CNT_W'(kft_pkg::ENTRIES)))
        else $error("drop with room left");
`endif

endmodule
